FILE: rtl/ccf_pkg.sv
`timescale 1ns / 1ps

package ccf_pkg;

	localparam int unsigned TIME_W    = 32;
	localparam int unsigned CODE_W    = 10;
	localparam int unsigned ISUM_W    = 15;
	localparam int unsigned MS_W      = 16;
	localparam int unsigned STATE_W   = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;

	// charge_state codes as seen on the result channel
	localparam logic [STATE_W-1:0] ST_IDLE     = 2'd0;
	localparam logic [STATE_W-1:0] ST_CHARGING = 2'd1;
	localparam logic [STATE_W-1:0] ST_DONE     = 2'd2;
	localparam logic [STATE_W-1:0] ST_FAULT    = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FULL_VOLTAGE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLTAGE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIM     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK        = 3'd5;

	localparam logic [CODE_W-1:0] FULL_VOLTAGE_RST = 10'd234;
	localparam logic [CODE_W-1:0] MIN_VOLTAGE_RST  = 10'd167;
	localparam logic [ISUM_W-1:0] CURRENT_LIM_RST  = 15'd14014;
	localparam logic [CODE_W-1:0] TEMP_LIM_RST     = 10'd123;
	localparam logic [MS_W-1:0]   DEBOUNCE_RST     = 16'd50;
	localparam logic [MS_W-1:0]   BLINK_RST        = 16'd300;

	typedef struct packed {
		logic advance;
		logic run;
	} dbc_ctrl_t;

endpackage

FILE: rtl/ccf_if.sv
`timescale 1ns / 1ps

interface ccf_tick_if;
	logic                            valid;
	logic                            ready;
	logic [ccf_pkg::TIME_W-1:0]      now_ms;
	logic                            button_level;
	logic [ccf_pkg::CODE_W-1:0]      battery_code;
	logic [ccf_pkg::ISUM_W-1:0]      current_sum;
	logic [ccf_pkg::CODE_W-1:0]      temp_code;

	modport source (output valid, now_ms, button_level, battery_code, current_sum, temp_code,
		input ready);
	modport sink (input valid, now_ms, button_level, battery_code, current_sum, temp_code,
		output ready);
endinterface

interface ccf_result_if;
	logic                            valid;
	logic                            ready;
	logic                            relay_on;
	logic                            led_charging;
	logic                            led_done;
	logic                            led_fault;
	logic [ccf_pkg::STATE_W-1:0]     charge_state;

	modport source (output valid, relay_on, led_charging, led_done, led_fault, charge_state,
		input ready);
	modport sink (input valid, relay_on, led_charging, led_done, led_fault, charge_state,
		output ready);
endinterface

interface ccf_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ccf_pkg::CFG_IDX_W-1:0]   index;
	logic [ccf_pkg::CFG_DAT_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/ccf_debounce.sv
`timescale 1ns / 1ps

module ccf_debounce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ccf_pkg::dbc_ctrl_t            ctrl,
	input  logic                          pressed,
	input  logic [ccf_pkg::TIME_W-1:0]    now_ms,
	input  logic [ccf_pkg::MS_W-1:0]      debounce_ms,
	output logic                          press
);

	logic                         button_seen_q;
	logic [ccf_pkg::TIME_W-1:0]   change_time_q;
	logic                         await_release_q;
	logic                         blocked;
	logic                         changed;
	logic [ccf_pkg::TIME_W-1:0]   elapsed;

	assign blocked = await_release_q && pressed;
	assign changed = (pressed != button_seen_q);
	assign elapsed = now_ms - change_time_q;

	// a fresh edge restarts the timer, so it can never qualify on the same tick
	assign press = ctrl.run && !blocked && pressed && !changed &&
		(elapsed > {{(ccf_pkg::TIME_W-ccf_pkg::MS_W){1'b0}}, debounce_ms});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_seen_q   <= 1'b1;
			change_time_q   <= '0;
			await_release_q <= 1'b0;
		end else if (ctrl.advance) begin
			if (ctrl.run) begin
				await_release_q <= blocked || press;
				if (!blocked && changed) begin
					button_seen_q <= pressed;
					change_time_q <= now_ms;
				end
			end else begin
				await_release_q <= blocked;
			end
		end
	end

endmodule

FILE: rtl/charge_controller_fsm_top.sv
`timescale 1ns / 1ps

// Battery charge controller state machine.
// tick (sink): one sample per transfer - timestamp, raw button level and the
//   battery, current-sum and temperature ADC codes.
// result (source): one item per tick - relay, three LEDs and the new state.
// cfg (sink): register writes, index 0..5 (full voltage, min voltage, current
//   limit, temperature limit, debounce time, blink time); other indexes are
//   dropped. Always ready; write only while no tick is in flight.
// Path: a tick is registered on transfer in the input register, evaluated
//   against the state registers and lands in the result register, where its
//   result is presented as valid.
// Throughput: one tick per clock unless result.ready is low; one state update per tick.
// Stall: the result register holds while result.ready is low; one more tick
//   waits in the input register, after which tick.ready drops.
// Reset: state returns to idle with the button taken as pressed, timers at
//   zero and the config registers at their defaults; both channels empty.
module charge_controller_fsm_top (
	input  logic          clk,
	input  logic          arst_n,
	ccf_tick_if.sink      tick,
	ccf_result_if.source  result,
	ccf_cfg_if.sink       cfg
);

	typedef enum logic [ccf_pkg::STATE_W-1:0] {
		MODE_IDLE     = ccf_pkg::ST_IDLE,
		MODE_CHARGING = ccf_pkg::ST_CHARGING,
		MODE_DONE     = ccf_pkg::ST_DONE,
		MODE_FAULT    = ccf_pkg::ST_FAULT
	} mode_t;

	logic [ccf_pkg::CODE_W-1:0] full_voltage_q;
	logic [ccf_pkg::CODE_W-1:0] min_voltage_q;
	logic [ccf_pkg::ISUM_W-1:0] current_lim_q;
	logic [ccf_pkg::CODE_W-1:0] temp_lim_q;
	logic [ccf_pkg::MS_W-1:0]   debounce_q;
	logic [ccf_pkg::MS_W-1:0]   blink_q;

	logic                       valid_s1;
	logic [ccf_pkg::TIME_W-1:0] now_s1;
	logic                       button_s1;
	logic [ccf_pkg::CODE_W-1:0] battery_s1;
	logic [ccf_pkg::ISUM_W-1:0] isum_s1;
	logic [ccf_pkg::CODE_W-1:0] temp_s1;

	mode_t                      mode_q;
	mode_t                      mode_next;
	logic                       blink_phase_q;
	logic [ccf_pkg::TIME_W-1:0] last_toggle_q;
	logic                       fault_led_q;

	logic                       res_valid_q;
	logic                       relay_q;
	logic                       led_charging_q;
	logic                       led_done_q;
	logic                       led_fault_q;
	logic [ccf_pkg::STATE_W-1:0] state_q;

	logic                       out_free;
	logic                       advance;
	logic                       pressed;
	logic                       press;
	logic                       fault_hit;
	logic                       toggle_due;
	logic                       led_next;
	logic [ccf_pkg::TIME_W-1:0] blink_elapsed;
	ccf_pkg::dbc_ctrl_t         dbc_ctrl;

	assign out_free   = !res_valid_q || result.ready;
	assign advance    = valid_s1 && out_free;
	assign tick.ready = !valid_s1 || out_free;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_voltage_q <= ccf_pkg::FULL_VOLTAGE_RST;
			min_voltage_q  <= ccf_pkg::MIN_VOLTAGE_RST;
			current_lim_q  <= ccf_pkg::CURRENT_LIM_RST;
			temp_lim_q     <= ccf_pkg::TEMP_LIM_RST;
			debounce_q     <= ccf_pkg::DEBOUNCE_RST;
			blink_q        <= ccf_pkg::BLINK_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				ccf_pkg::REG_FULL_VOLTAGE: full_voltage_q <= cfg.data[ccf_pkg::CODE_W-1:0];
				ccf_pkg::REG_MIN_VOLTAGE:  min_voltage_q  <= cfg.data[ccf_pkg::CODE_W-1:0];
				ccf_pkg::REG_CURRENT_LIM:  current_lim_q  <= cfg.data[ccf_pkg::ISUM_W-1:0];
				ccf_pkg::REG_TEMP_LIM:     temp_lim_q     <= cfg.data[ccf_pkg::CODE_W-1:0];
				ccf_pkg::REG_DEBOUNCE:     debounce_q     <= cfg.data;
				ccf_pkg::REG_BLINK:        blink_q        <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			now_s1     <= tick.now_ms;
			button_s1  <= tick.button_level;
			battery_s1 <= tick.battery_code;
			isum_s1    <= tick.current_sum;
			temp_s1    <= tick.temp_code;
		end
	end

	assign pressed        = !button_s1;
	assign dbc_ctrl.advance = advance;
	assign dbc_ctrl.run     = (mode_q != MODE_CHARGING);

	ccf_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (dbc_ctrl),
		.pressed     (pressed),
		.now_ms      (now_s1),
		.debounce_ms (debounce_q),
		.press       (press)
	);

	assign fault_hit = (battery_s1 < min_voltage_q) || (isum_s1 > current_lim_q) ||
		(temp_s1 > temp_lim_q);

	always_comb begin
		mode_next = mode_q;
		case (mode_q)
			MODE_CHARGING: begin
				if (fault_hit)
					mode_next = MODE_FAULT;
				else if (battery_s1 >= full_voltage_q)
					mode_next = MODE_DONE;
			end
			MODE_IDLE: begin
				if (press)
					mode_next = (battery_s1 < full_voltage_q && battery_s1 > min_voltage_q) ?
						MODE_CHARGING : MODE_FAULT;
			end
			default: begin
				if (press)
					mode_next = MODE_IDLE;
			end
		endcase
	end

	assign blink_elapsed = now_s1 - last_toggle_q;
	assign toggle_due    = (mode_next == MODE_FAULT) &&
		(blink_elapsed > {{(ccf_pkg::TIME_W-ccf_pkg::MS_W){1'b0}}, blink_q});
	assign led_next      = (mode_next != MODE_FAULT) ? 1'b0 :
		(toggle_due ? !blink_phase_q : fault_led_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			blink_phase_q <= 1'b0;
			last_toggle_q <= '0;
			fault_led_q   <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				mode_q      <= mode_next;
				fault_led_q <= led_next;
				if (toggle_due) begin
					blink_phase_q <= !blink_phase_q;
					last_toggle_q <= now_s1;
				end
			end
			if (out_free)
				res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			relay_q        <= (mode_q == MODE_CHARGING);
			led_charging_q <= (mode_next == MODE_CHARGING);
			led_done_q     <= (mode_next == MODE_DONE);
			led_fault_q    <= led_next;
			state_q        <= mode_next;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.relay_on     = relay_q;
	assign result.led_charging = led_charging_q;
	assign result.led_done     = led_done_q;
	assign result.led_fault    = led_fault_q;
	assign result.charge_state = state_q;

endmodule

FILE: rtl/ccf_checker.sv
`timescale 1ns / 1ps

module ccf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic                          relay_on,
	input logic                          led_charging,
	input logic                          led_done,
	input logic                          led_fault,
	input logic [ccf_pkg::STATE_W-1:0]   charge_state
);

	property p_res_hold;
		@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(charge_state) && $stable(led_fault)
			&& $stable(relay_on);
	endproperty
	a_res_hold: assert property (p_res_hold) else $error("result changed while stalled");

	property p_led_charging;
		@(posedge clk) disable iff (!arst_n)
		res_valid |-> led_charging == (charge_state == ccf_pkg::ST_CHARGING);
	endproperty
	a_led_charging: assert property (p_led_charging) else $error("charging LED mismatch");

	property p_led_done;
		@(posedge clk) disable iff (!arst_n)
		res_valid |-> led_done == (charge_state == ccf_pkg::ST_DONE);
	endproperty
	a_led_done: assert property (p_led_done) else $error("done LED mismatch");

	property p_led_fault;
		@(posedge clk) disable iff (!arst_n)
		res_valid && led_fault |-> charge_state == ccf_pkg::ST_FAULT;
	endproperty
	a_led_fault: assert property (p_led_fault) else $error("fault LED lit outside fault");

endmodule

bind charge_controller_fsm_top ccf_checker u_ccf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.relay_on     (result.relay_on),
	.led_charging (result.led_charging),
	.led_done     (result.led_done),
	.led_fault    (result.led_fault),
	.charge_state (result.charge_state)
);
